// File: hw/rtl/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// Types, opcodes and byte tables shared by the character-LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic       end_of_message;
  } req_item_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic       last;
  } nib_item_t;

  // One nibble handed from the sequencer to the output register.
  typedef struct packed {
    logic       fire;
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } emit_t;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_SETUP     = 3'd1;
  localparam logic [2:0] OP_SHIFT_R   = 3'd2;
  localparam logic [2:0] OP_SHIFT_L   = 3'd3;
  localparam logic [2:0] OP_RAW       = 3'd4;
  localparam logic [2:0] OP_TEXT      = 3'd5;

  // Byte-list kinds held by the sequencer while an item is being sent.
  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_SETUP   = 3'd1;
  localparam logic [2:0] KIND_SHIFT_R = 3'd2;
  localparam logic [2:0] KIND_SHIFT_L = 3'd3;
  localparam logic [2:0] KIND_RAW     = 3'd4;
  localparam logic [2:0] KIND_TEXT    = 3'd5;
  localparam logic [2:0] KIND_TEXT_NL = 3'd6;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME_L1  = 8'h80;
  localparam logic [7:0] CMD_HOME_L2  = 8'hC0;
  localparam logic [7:0] CMD_SHIFT_R  = 8'h14;
  localparam logic [7:0] CMD_SHIFT_L  = 8'h10;
  localparam int         SETUP_LEN    = 8;

  function automatic logic [7:0] setup_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h08;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      3'd6:    b = 8'h0C;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  // Byte number idx of the list that a kind stands for.
  function automatic logic [7:0] list_byte(input logic [2:0] kind, input logic [2:0] idx,
                                           input logic [7:0] val);
    logic [7:0] b;
    case (kind)
      KIND_CLEAR:   b = idx[0] ? CMD_HOME_L1 : CMD_CLEAR;
      KIND_SETUP:   b = setup_byte(idx);
      KIND_SHIFT_R: b = CMD_SHIFT_R;
      KIND_SHIFT_L: b = CMD_SHIFT_L;
      KIND_TEXT_NL: b = idx[0] ? val : CMD_HOME_L2;
      default:      b = val;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/clns_ctrl.sv
// ----------------------------------------------------------------------------
// clns_ctrl
// Request decoder, text position tracking and the byte/nibble sequencer.
// ----------------------------------------------------------------------------
module clns_ctrl #(
  parameter int LINE_LEN  = 16,
  parameter int MAX_SHIFT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  clns_pkg::req_item_t req,
  output logic              req_stall,
  input  logic              take,
  output clns_pkg::emit_t   emit
);
  import clns_pkg::*;

  localparam int MAX_BYTES = (MAX_SHIFT > SETUP_LEN) ? MAX_SHIFT : SETUP_LEN;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int POS_W     = $clog2(2 * LINE_LEN + 1);

  logic             busy;
  logic             phase;
  logic [2:0]       kind;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] total;
  logic [7:0]       val;
  logic [POS_W-1:0] text_position;
  logic             text_stopped;

  logic             accept;
  logic [2:0]       kind_next;
  logic [CNT_W-1:0] total_next;
  logic [7:0]       shift_cnt;
  logic             text_send;
  logic [CNT_W-1:0] idx_inc;
  logic             last_byte;
  logic             fire;
  logic [7:0]       cur;

  assign accept    = req_valid && !busy;
  assign req_stall = busy;

  assign shift_cnt = (req.value > 8'(MAX_SHIFT)) ? 8'(MAX_SHIFT) : req.value;
  assign text_send = !text_stopped && (req.value != 8'd0) &&
                     (text_position < POS_W'(2 * LINE_LEN));

  always_comb begin
    kind_next  = KIND_RAW;
    total_next = '0;
    case (req.opcode)
      OP_CLEAR: begin
        kind_next  = KIND_CLEAR;
        total_next = CNT_W'(2);
      end
      OP_SETUP: begin
        kind_next  = KIND_SETUP;
        total_next = CNT_W'(SETUP_LEN);
      end
      OP_SHIFT_R: begin
        kind_next  = KIND_SHIFT_R;
        total_next = shift_cnt[CNT_W-1:0];
      end
      OP_SHIFT_L: begin
        kind_next  = KIND_SHIFT_L;
        total_next = shift_cnt[CNT_W-1:0];
      end
      OP_RAW: begin
        kind_next  = KIND_RAW;
        total_next = CNT_W'(1);
      end
      OP_TEXT: begin
        // Crossing into the second line puts the line-two address first.
        if (text_send && (text_position == POS_W'(LINE_LEN))) begin
          kind_next  = KIND_TEXT_NL;
          total_next = CNT_W'(2);
        end else begin
          kind_next  = KIND_TEXT;
          total_next = text_send ? CNT_W'(1) : CNT_W'(0);
        end
      end
      default: begin
        kind_next  = KIND_RAW;
        total_next = '0;
      end
    endcase
  end

  // The one counter/compare unit walks the byte list, two nibbles per byte.
  assign idx_inc   = idx + CNT_W'(1);
  assign last_byte = (idx_inc == total);
  assign fire      = busy && take;
  assign cur       = list_byte(kind, idx[2:0], val);

  assign emit.fire   = fire;
  assign emit.rs     = (kind == KIND_TEXT) || ((kind == KIND_TEXT_NL) && idx[0]);
  assign emit.nibble = phase ? cur[3:0] : cur[7:4];
  assign emit.last   = phase && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      phase         <= 1'b0;
      text_position <= '0;
      text_stopped  <= 1'b0;
    end else begin
      if (accept) begin
        kind  <= kind_next;
        total <= total_next;
        val   <= req.value;
        idx   <= '0;
        phase <= 1'b0;
        busy  <= (total_next != '0);
        if (req.opcode == OP_TEXT) begin
          if (req.end_of_message) begin
            text_position <= '0;
            text_stopped  <= 1'b0;
          end else if (!text_stopped && (req.value == 8'd0)) begin
            text_stopped <= 1'b1;
          end else if (text_send) begin
            text_position <= text_position + POS_W'(1);
          end
        end
      end else if (fire) begin
        phase <= !phase;
        if (phase) begin
          idx <= idx_inc;
          if (last_byte) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/clns_out.sv
// ----------------------------------------------------------------------------
// clns_out
// Output register for nibble items; holds a stalled item and frees the
// sequencer as soon as the register can be refilled.
// ----------------------------------------------------------------------------
module clns_out (
  input  logic              clk,
  input  logic              rst,
  input  clns_pkg::emit_t   emit,
  output logic              take,
  output logic              nib_valid,
  input  logic              nib_stall,
  output clns_pkg::nib_item_t nib
);
  import clns_pkg::*;

  assign take = !nib_valid || !nib_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      nib_valid <= 1'b0;
    end else if (take) begin
      nib_valid <= emit.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit.fire) begin
      nib.register_select <= emit.rs;
      nib.nibble          <= emit.nibble;
      nib.last            <= emit.last;
    end
  end

endmodule

// File: hw/rtl/char_lcd_nibble_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_sequencer_core
// Turns display requests into 4-bit LCD bus transfers, high nibble first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | opcode, value, end_of_message
//  nib     | out       | nib_valid / nib_stall | register_select, nibble, last
//
// A request that sends k nibbles holds req_stall until its last one is taken;
// one nibble leaves the sequencer's byte counter per cycle when the output is
// not stalled. Requests that send nothing never stall. Setup sends 16 nibbles,
// a full shift 2*MAX_SHIFT. Output stalls pause the sequencer nibble by nibble.
// Synchronous reset clears the text position, the stop flag and the output.
module char_lcd_nibble_command_sequencer_core #(
  parameter int LINE_LEN  = 16,
  parameter int MAX_SHIFT = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  clns_pkg::req_item_t req,
  output logic                nib_valid,
  input  logic                nib_stall,
  output clns_pkg::nib_item_t nib
);
  import clns_pkg::*;

  emit_t emit;
  logic  take;

  clns_ctrl #(
    .LINE_LEN  (LINE_LEN),
    .MAX_SHIFT (MAX_SHIFT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .take      (take),
    .emit      (emit)
  );

  clns_out u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .take      (take),
    .nib_valid (nib_valid),
    .nib_stall (nib_stall),
    .nib       (nib)
  );

endmodule

// File: hw/rtl/clns_checker.sv
// ----------------------------------------------------------------------------
// clns_checker
// Port-level checks for the nibble sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module clns_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input clns_pkg::req_item_t req,
  input logic                nib_valid,
  input logic                nib_stall,
  input clns_pkg::nib_item_t nib
);
  import clns_pkg::*;

  // A stalled item keeps its place and contents.
  a_nib_hold: assert property (@(posedge clk) disable iff (rst)
    nib_valid && nib_stall |=> nib_valid && $stable(nib))
    else $error("stalled nibble item changed");

  // While a nibble that is not the last of its request waits, no new request enters.
  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    nib_valid && !nib.last |-> req_stall)
    else $error("request accepted in the middle of a nibble sequence");

  // Clear, setup and raw requests always send something, so the block is busy next.
  a_busy_after_fixed: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall &&
    (req.opcode == OP_CLEAR || req.opcode == OP_SETUP || req.opcode == OP_RAW)
    |=> req_stall)
    else $error("fixed-length request did not start a sequence");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !nib_valid)
    else $error("output valid after reset");

endmodule

bind char_lcd_nibble_command_sequencer_core clns_checker u_clns_checker (.*);
